// ===== hw/rtl/knn_pkg.sv =====
// ----------------------------------------------------------------------------
// knn_pkg
// Shared types and codes of the squared Euclidean k-nearest-neighbor block.
// ----------------------------------------------------------------------------
package knn_pkg;

    localparam int IDX_W  = 12;
    localparam int DIST_W = 48;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [1:0] REG_NUM_NEIGHBORS  = 2'd0;
    localparam logic [1:0] REG_VECTORS_IN_USE = 2'd1;
    localparam logic [1:0] REG_DIMS_IN_USE    = 2'd2;

    typedef struct packed {
        logic               op;
        logic [11:0]        vec_index;
        logic [5:0]         dim_index;
        logic signed [15:0] component;
    } t_in;

    typedef struct packed {
        logic [11:0] neighbor_index;
        logic [47:0] distance;
        logic [4:0]  rank;
        logic        last;
    } t_out;

    typedef struct packed {
        logic              valid;
        logic [IDX_W-1:0]  idx;
        logic [DIST_W-1:0] dist_sq;
    } t_entry;

    typedef struct packed {
        logic clear;
        logic offer;
        logic shift;
    } t_cell_ctl;

endpackage

// ===== hw/rtl/knn_cell.sv =====
// ----------------------------------------------------------------------------
// knn_cell
// One slot of the sorted neighbor list: insert, shift down on insert, shift
// toward the head on readout.
// ----------------------------------------------------------------------------
module knn_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  knn_pkg::t_cell_ctl i_ctl,
    input  logic               i_en,
    input  knn_pkg::t_entry    i_new,
    input  knn_pkg::t_entry    i_prev,
    input  logic               i_prev_ins,
    input  knn_pkg::t_entry    i_next,
    output knn_pkg::t_entry    o_ent,
    output logic               o_ins
);
    import knn_pkg::*;

    t_entry r_ent;
    logic   w_ins;

    assign w_ins = i_en && (!r_ent.valid || (i_new.dist_sq < r_ent.dist_sq));
    assign o_ins = w_ins;
    assign o_ent = r_ent;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent.valid <= 1'b0;
        end else if (i_ctl.clear) begin
            r_ent.valid <= 1'b0;
        end else if (i_ctl.shift) begin
            r_ent <= i_next;
        end else if (i_ctl.offer && i_en) begin
            if (i_prev_ins) begin
                r_ent <= i_prev;
            end else if (w_ins) begin
                r_ent <= i_new;
            end
        end
    end

endmodule

// ===== hw/rtl/knn_squared_euclidean_topk.sv =====
// ----------------------------------------------------------------------------
// knn_squared_euclidean_topk
// Brute-force nearest-neighbor search over a table of fixed-point vectors.
// ----------------------------------------------------------------------------
// Usage: present a word on i_cmd with start high; it is taken when busy is
// low. A load word (op 0) writes one component, leaves busy low and gives
// no result. A query word (op 1) walks every vector in use but the query
// vector itself, one component pair per cycle read from the two read ports
// of the vector table; busy stays high until the results have left.
// Distances accumulate in a short pipeline and feed a chain of cells that
// keeps the sorted best list. Results then leave one per cycle on o_result,
// marked by o_valid, nearest first, the final one with last set; the
// receiver cannot stall them.
// Config writes through i_cfg_we/i_cfg_index/i_cfg_data take effect at
// once and must only happen while busy is low. Reset restores register
// defaults and empties the list; the table contents stay undefined.
// ----------------------------------------------------------------------------
module knn_squared_euclidean_topk #(
    parameter int MAX_VECTORS    = 4096,
    parameter int MAX_DIMS       = 64,
    parameter int MAX_NEIGHBORS  = 32,
    parameter int COMPONENT_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  knn_pkg::t_in  i_cmd,
    output logic          busy,
    output logic          o_valid,
    output knn_pkg::t_out o_result,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_index,
    input  logic [12:0]   i_cfg_data
);
    import knn_pkg::*;

    localparam int CW    = (COMPONENT_BITS < 16) ? COMPONENT_BITS : 16;
    localparam int DEPTH = MAX_VECTORS * MAX_DIMS;
    localparam int AW    = $clog2(DEPTH);

    typedef enum logic [1:0] {S_IDLE, S_RUN, S_DRAIN, S_EMIT} t_state;

    t_state      r_state;
    logic [5:0]  r_cfg_k;
    logic [12:0] r_cfg_nv;
    logic [6:0]  r_cfg_nd;
    logic [5:0]  r_k;
    logic [12:0] r_nv;
    logic [6:0]  r_nd;
    logic [11:0] r_q;
    logic [12:0] r_i;
    logic [6:0]  r_d;
    logic [2:0]  r_drain;
    logic [5:0]  r_rank;
    logic        r_out_v;
    t_out        r_out;

    logic [CW-1:0] r_mem [DEPTH];
    logic [CW-1:0] r_da, r_db;
    logic          r1_v, r1_first, r1_last, r1_zero;
    logic [11:0]   r1_idx;
    logic          r2_v, r2_first, r2_last, r2_zero;
    logic [11:0]   r2_idx;
    logic [33:0]   r_sq;
    logic [47:0]   r_acc, n_acc;
    logic          r_off_v;
    logic [47:0]   r_off_d;
    logic [11:0]   r_off_idx;

    logic        w_accept, w_load_ok, w_query_ok, w_skip, w_issue, w_first, w_lastd, w_zero;
    logic [5:0]  w_k;
    logic [12:0] w_nv;
    logic [6:0]  w_nd;
    logic [AW-1:0] w_wa, w_aa, w_ab;
    logic signed [16:0] w_xa, w_xb, w_diff;
    logic signed [33:0] w_sq;
    t_cell_ctl   w_ctl;
    t_entry      w_new;
    t_entry      w_ent [MAX_NEIGHBORS];
    logic        w_ins [MAX_NEIGHBORS];
    logic        w_more;

    assign busy     = (r_state != S_IDLE);
    assign o_valid  = r_out_v;
    assign o_result = r_out;

    assign w_accept   = start && !busy;
    assign w_load_ok  = (int'(i_cmd.vec_index) < MAX_VECTORS) &&
                        (int'(i_cmd.dim_index) < MAX_DIMS);
    assign w_k  = (int'(r_cfg_k) > MAX_NEIGHBORS) ? 6'(MAX_NEIGHBORS) : r_cfg_k;
    assign w_nv = (int'(r_cfg_nv) > MAX_VECTORS) ? 13'(MAX_VECTORS) : r_cfg_nv;
    assign w_nd = (int'(r_cfg_nd) > MAX_DIMS) ? 7'(MAX_DIMS) : r_cfg_nd;
    assign w_query_ok = w_accept && (i_cmd.op == OP_QUERY) &&
                        (int'(i_cmd.vec_index) < MAX_VECTORS) && (w_k != 6'd0);

    assign w_skip  = (r_i == {1'b0, r_q});
    assign w_issue = (r_state == S_RUN) && (r_i < r_nv) && !w_skip;
    assign w_zero  = (r_nd == 7'd0);
    assign w_first = (r_d == 7'd0);
    assign w_lastd = w_zero || (r_d == r_nd - 7'd1);

    assign w_wa = AW'(int'(i_cmd.vec_index) * MAX_DIMS + int'(i_cmd.dim_index));
    assign w_aa = AW'(int'(r_q) * MAX_DIMS + int'(r_d));
    assign w_ab = AW'(int'(r_i) * MAX_DIMS + int'(r_d));

    always_ff @(posedge i_clk) begin
        if (w_accept && (i_cmd.op == OP_LOAD) && w_load_ok) begin
            r_mem[w_wa] <= i_cmd.component[CW-1:0];
        end
        r_da <= r_mem[w_aa];
        r_db <= r_mem[w_ab];
    end

    assign w_xa   = 17'(signed'(r_da));
    assign w_xb   = 17'(signed'(r_db));
    assign w_diff = w_xa - w_xb;
    assign w_sq   = 34'(w_diff) * 34'(w_diff);
    assign n_acc  = (r2_first ? 48'd0 : r_acc) + (r2_zero ? 48'd0 : 48'(r_sq));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v    <= 1'b0;
            r2_v    <= 1'b0;
            r_off_v <= 1'b0;
        end else begin
            r1_v    <= w_issue;
            r2_v    <= r1_v;
            r_off_v <= r2_v && r2_last;
        end
        r1_first  <= w_first;
        r1_last   <= w_lastd;
        r1_zero   <= w_zero;
        r1_idx    <= 12'(r_i);
        r2_first  <= r1_first;
        r2_last   <= r1_last;
        r2_zero   <= r1_zero;
        r2_idx    <= r1_idx;
        r_sq      <= 34'(unsigned'(w_sq));
        if (r2_v) begin
            r_acc <= n_acc;
        end
        r_off_d   <= n_acc;
        r_off_idx <= r2_idx;
    end

    assign w_ctl.clear = w_query_ok;
    assign w_ctl.offer = r_off_v;
    assign w_ctl.shift = (r_state == S_EMIT);
    assign w_new = '{valid: 1'b1, idx: r_off_idx, dist_sq: r_off_d};

    for (genvar j = 0; j < MAX_NEIGHBORS; j++) begin : g_cell
        t_entry w_prev, w_next;
        logic   w_prev_ins, w_en;
        if (j == 0) begin : g_head
            assign w_prev     = '0;
            assign w_prev_ins = 1'b0;
        end else begin : g_body
            assign w_prev     = w_ent[j-1];
            assign w_prev_ins = w_ins[j-1];
        end
        if (j == MAX_NEIGHBORS - 1) begin : g_tail
            assign w_next = '0;
        end else begin : g_inner
            assign w_next = w_ent[j+1];
        end
        assign w_en = (7'(j) < {1'b0, r_k});
        knn_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl),
            .i_en       (w_en),
            .i_new      (w_new),
            .i_prev     (w_prev),
            .i_prev_ins (w_prev_ins),
            .i_next     (w_next),
            .o_ent      (w_ent[j]),
            .o_ins      (w_ins[j])
        );
    end

    if (MAX_NEIGHBORS > 1) begin : g_more
        assign w_more = w_ent[1].valid;
    end else begin : g_single
        assign w_more = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cfg_k  <= 6'd10;
            r_cfg_nv <= 13'd4096;
            r_cfg_nd <= 7'd64;
            r_out_v  <= 1'b0;
        end else begin
            r_out_v <= 1'b0;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_NUM_NEIGHBORS:  r_cfg_k  <= i_cfg_data[5:0];
                    REG_VECTORS_IN_USE: r_cfg_nv <= i_cfg_data;
                    REG_DIMS_IN_USE:    r_cfg_nd <= i_cfg_data[6:0];
                    default: ;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_query_ok) begin
                        r_state <= S_RUN;
                        r_k     <= w_k;
                        r_nv    <= w_nv;
                        r_nd    <= w_nd;
                        r_q     <= i_cmd.vec_index;
                        r_i     <= 13'd0;
                        r_d     <= 7'd0;
                        r_rank  <= 6'd0;
                    end
                end
                S_RUN: begin
                    if (r_i >= r_nv) begin
                        r_state <= S_DRAIN;
                        r_drain <= 3'd0;
                    end else if (w_skip || w_lastd) begin
                        r_i <= r_i + 13'd1;
                        r_d <= 7'd0;
                    end else begin
                        r_d <= r_d + 7'd1;
                    end
                end
                S_DRAIN: begin
                    r_drain <= r_drain + 3'd1;
                    if (r_drain == 3'd4) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (w_ent[0].valid) begin
                        r_out_v <= 1'b1;
                        r_out   <= '{neighbor_index: w_ent[0].idx,
                                     distance: w_ent[0].dist_sq,
                                     rank: 5'(r_rank),
                                     last: !w_more};
                        r_rank  <= r_rank + 6'd1;
                        if (!w_more) begin
                            r_state <= S_IDLE;
                        end
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== hw/rtl/knn_checker.sv =====
// ----------------------------------------------------------------------------
// knn_checker
// Port-level checks of the nearest-neighbor block's result sequence and of loads.
// ----------------------------------------------------------------------------
module knn_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          start,
    input knn_pkg::t_in  i_cmd,
    input logic          busy,
    input logic          o_valid,
    input knn_pkg::t_out o_result
);
    import knn_pkg::*;

    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result word outside a query");

    a_rank_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_result.last) |=>
            (o_valid && (o_result.rank == $past(o_result.rank) + 5'd1)))
        else $error("result words not consecutive");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.last) |=> !o_valid)
        else $error("word after last");

    a_load_quick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_cmd.op == OP_LOAD)) |=> !busy)
        else $error("load held the block busy");

endmodule

bind knn_squared_euclidean_topk knn_checker u_knn_checker (.*);
